/* rtl/trk_pkg.sv */
// shared types and constants for the session and opening range tracker
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package trk_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 8;
	localparam int unsigned CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STALE_MODE  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPREAD_MAX  = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_MIN   = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IB_MINUTES  = 8'd3;

	// stale book handling codes
	localparam logic [1:0] STALE_SUPPRESS = 2'd0;
	localparam logic [1:0] STALE_ZERO     = 2'd1;
	localparam logic [1:0] STALE_CONTINUE = 2'd2;

	// field widths fixed by the interface
	localparam int unsigned DAY_BITS   = 16;
	localparam int unsigned TIME_BITS  = 32;
	localparam int unsigned DEPTH_BITS = 8;
	localparam int unsigned POS_BITS   = 17;
	localparam int unsigned IBM_BITS   = 11;

	// close position divider: one quotient bit per step
	localparam int unsigned DIV_STEPS    = POS_BITS;
	localparam int unsigned DIV_CNT_BITS = 5;
	localparam logic [POS_BITS-1:0] POS_HALF = 17'd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SETUP,
		ST_DIV,
		ST_FINISH
	} trk_state_t;

	typedef struct packed {
		logic load;       // latch the accepted input transaction
		logic update;     // fold the bar into session and window state
		logic setup;      // load divider operands
		logic div_first;  // first divider step, no remainder shift
		logic div_step;   // one quotient bit
		logic out_load;   // move the result into the output register
	} trk_cmd_t;

	typedef struct packed {
		logic suppress;   // gate drops the result
		logic zero;       // gate asks for an all-zero result
		logic flat;       // session range is empty
		logic out_full;   // output register holds an untaken result
	} trk_sts_t;

endpackage

/* rtl/trk_ctrl.sv */
// controller state machine for the session and opening range tracker
// depends on trk_pkg for the state, command and status types
`timescale 1ns / 1ps

module trk_ctrl import trk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  trk_sts_t sts,
	output trk_cmd_t cmd
);

	trk_state_t              state_q, state_d;
	logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_SETUP;
			end
			ST_SETUP: begin
				if (sts.suppress) begin
					state_d = ST_IDLE;
				end else begin
					cmd.setup = 1'b1;
					cnt_d     = '0;
					if (sts.zero || sts.flat) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/trk_datapath.sv */
// datapath: configuration, session and window state, gate, divider, output register
// depends on trk_pkg for command and status types and constants
`timescale 1ns / 1ps

module trk_datapath import trk_pkg::*; #(
	parameter int unsigned PRICE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  trk_cmd_t                  cmd,
	output trk_sts_t                  sts,
	input  logic [DAY_BITS-1:0]       trading_day,
	input  logic [TIME_BITS-1:0]      bar_time,
	input  logic [PRICE_BITS-1:0]     bar_high,
	input  logic [PRICE_BITS-1:0]     bar_low,
	input  logic [PRICE_BITS-1:0]     bar_close,
	input  logic [PRICE_BITS-1:0]     best_bid,
	input  logic [PRICE_BITS-1:0]     best_ask,
	input  logic [DEPTH_BITS-1:0]     depth_levels,
	input  logic                      book_stale,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [PRICE_BITS-1:0]     open_high,
	output logic [PRICE_BITS-1:0]     open_low,
	output logic [PRICE_BITS-1:0]     open_range,
	output logic [PRICE_BITS-1:0]     day_high,
	output logic [PRICE_BITS-1:0]     day_low,
	output logic [PRICE_BITS-1:0]     day_range,
	output logic [POS_BITS-1:0]       close_position
);

	localparam int unsigned WEND_BITS = TIME_BITS + 1;

	// configuration
	logic [1:0]            stale_mode_q;
	logic [15:0]           spread_max_q;
	logic [DEPTH_BITS-1:0] depth_min_q;
	logic [IBM_BITS-1:0]   ib_minutes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_mode_q <= STALE_SUPPRESS;
			spread_max_q <= 16'd2;
			depth_min_q  <= 8'd10;
			ib_minutes_q <= 11'd60;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STALE_MODE: stale_mode_q <= cfg_data[1:0];
				REG_SPREAD_MAX: spread_max_q <= cfg_data;
				REG_DEPTH_MIN:  depth_min_q  <= cfg_data[DEPTH_BITS-1:0];
				REG_IB_MINUTES: ib_minutes_q <= cfg_data[IBM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// latched input transaction
	logic [DAY_BITS-1:0]   day_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [PRICE_BITS-1:0] hi_q, lo_q, cl_q, bid_q, ask_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  stale_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= trading_day;
			time_q  <= bar_time;
			hi_q    <= bar_high;
			lo_q    <= bar_low;
			cl_q    <= bar_close;
			bid_q   <= best_bid;
			ask_q   <= best_ask;
			depth_q <= depth_levels;
			stale_q <= book_stale;
		end
	end

	// session and opening window state
	logic                  started_q;
	logic [DAY_BITS-1:0]   cur_day_q;
	logic [TIME_BITS-1:0]  start_q;
	logic [PRICE_BITS-1:0] wh_q, wl_q, sh_q, sl_q;

	logic                  restart;
	logic [TIME_BITS-1:0]  start_eff;
	logic [PRICE_BITS-1:0] wh_b, wl_b, sh_b, sl_b;
	logic [IBM_BITS-1:0]   ibm;
	logic [WEND_BITS-1:0]  win_end;
	logic                  in_win;

	always_comb begin
		restart   = !started_q || (day_q != cur_day_q);
		start_eff = restart ? time_q : start_q;
		wh_b      = restart ? '0 : wh_q;
		wl_b      = restart ? '1 : wl_q;
		sh_b      = restart ? '0 : sh_q;
		sl_b      = restart ? '1 : sl_q;
		ibm       = (ib_minutes_q == '0) ? IBM_BITS'(1) : ib_minutes_q;
		// seconds in the window: minutes times sixty as (m << 6) - (m << 2)
		win_end   = {1'b0, start_eff}
		          + ((WEND_BITS'(ibm) << 6) - (WEND_BITS'(ibm) << 2));
		in_win    = {1'b0, time_q} <= win_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			cur_day_q <= '0;
			start_q   <= '0;
			wh_q      <= '0;
			wl_q      <= '1;
			sh_q      <= '0;
			sl_q      <= '1;
		end else if (cmd.update) begin
			started_q <= 1'b1;
			cur_day_q <= day_q;
			start_q   <= start_eff;
			wh_q      <= (in_win && hi_q > wh_b) ? hi_q : wh_b;
			wl_q      <= (in_win && lo_q < wl_b) ? lo_q : wl_b;
			sh_q      <= (hi_q > sh_b) ? hi_q : sh_b;
			sl_q      <= (lo_q < sl_b) ? lo_q : sl_b;
		end
	end

	// quote and book gate
	logic                  quotes, depth_low, stale_drop, stale_zero, spread_wide;
	logic                  drop_res, zero_res;
	logic [DEPTH_BITS-1:0] dmin;
	logic [PRICE_BITS-1:0] spread;

	always_comb begin
		quotes      = (bid_q != '0) && (ask_q != '0);
		dmin        = (depth_min_q == '0) ? DEPTH_BITS'(1) : depth_min_q;
		depth_low   = depth_q < dmin;
		stale_drop  = stale_q && (stale_mode_q == STALE_SUPPRESS);
		stale_zero  = stale_q && (stale_mode_q == STALE_ZERO);
		spread      = ask_q - bid_q;
		spread_wide = (ask_q > bid_q) && (spread > PRICE_BITS'(spread_max_q));
		zero_res    = quotes && !depth_low && stale_zero;
		drop_res    = quotes && (depth_low || stale_drop || (!stale_zero && spread_wide));
	end

	// close position divider, restoring, one quotient bit per step
	logic [PRICE_BITS-1:0] clamp, num, den;
	logic [PRICE_BITS-1:0] rem_q, den_q;
	logic [POS_BITS-1:0]   quo_q;
	logic [PRICE_BITS:0]   rem_sh, rem_sub;
	logic                  ge;
	logic                  range_flat;

	always_comb begin
		range_flat = !(sh_q > sl_q);
		if (cl_q < sl_q) begin
			clamp = sl_q;
		end else if (cl_q > sh_q) begin
			clamp = sh_q;
		end else begin
			clamp = cl_q;
		end
		num     = clamp - sl_q;
		den     = sh_q - sl_q;
		rem_sh  = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= range_flat ? POS_HALF : '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[PRICE_BITS-1:0] : rem_sh[PRICE_BITS-1:0];
			quo_q <= {quo_q[POS_BITS-2:0], ge};
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (zero_res) begin
				open_high      <= '0;
				open_low       <= '0;
				open_range     <= '0;
				day_high       <= '0;
				day_low        <= '0;
				day_range      <= '0;
				close_position <= '0;
			end else begin
				open_high      <= wh_q;
				open_low       <= wl_q;
				open_range     <= (wh_q > wl_q) ? wh_q - wl_q : '0;
				day_high       <= sh_q;
				day_low        <= sl_q;
				day_range      <= range_flat ? '0 : den;
				close_position <= quo_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sts       = '{suppress: drop_res, zero: zero_res, flat: range_flat,
	                     out_full: out_valid_q && !out_ready};

endmodule

/* rtl/session_and_opening_range_tracker.sv */
// top level of the session and opening range tracker: stream ports, packing
// depends on trk_pkg, trk_ctrl and trk_datapath
`timescale 1ns / 1ps

// Tracks the session high and low, restarted on every change of trading day,
// and the opening-window high and low over bars that start no later than
// ib_minutes after the first bar of the session. Every accepted bar updates
// the state; a result follows only when the quote and book gate lets it
// through (the gate applies only when both quotes are nonzero: depth check,
// then frozen-book handling per stale_mode, then the spread limit). Each
// transaction runs through the controller states in order: fold in the bar,
// set up the gate and divider operands, run the restoring divider that
// yields one quotient bit of the Q1.16 close position per cycle, then load
// the output register once it is free; the next transaction is taken only
// after the controller is back in idle, so bars are not overlapped. A flat
// range or an all-zero result skips the divider, and a suppressed item
// frees the input straight after the gate.
// A finished result sits in an output register, so the next transaction is
// taken while it waits; it then waits itself only if that register is full.
// Configuration writes are always taken and should happen while idle.
module session_and_opening_range_tracker import trk_pkg::*; #(
	parameter int unsigned PRICE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input bars
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// trading_day, bar_time, bar_high, bar_low, bar_close, best_bid, best_ask,
	// depth_levels, zero padding
	input  logic [((DAY_BITS + TIME_BITS + 5 * PRICE_BITS + DEPTH_BITS + 7) / 8) * 8 - 1:0]
	                                  s_tdata,
	// book_stale
	input  logic                      s_tuser,
	// results
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// open_high, open_low, open_range, day_high, day_low, day_range,
	// close_position, zero padding
	output logic [((6 * PRICE_BITS + POS_BITS + 7) / 8) * 8 - 1:0]
	                                  m_tdata
);

	localparam int unsigned OUT_BITS  = 6 * PRICE_BITS + POS_BITS;
	localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	// input field offsets in s_tdata
	localparam int unsigned O_TIME  = DAY_BITS;
	localparam int unsigned O_HIGH  = O_TIME + TIME_BITS;
	localparam int unsigned O_LOW   = O_HIGH + PRICE_BITS;
	localparam int unsigned O_CLOSE = O_LOW + PRICE_BITS;
	localparam int unsigned O_BID   = O_CLOSE + PRICE_BITS;
	localparam int unsigned O_ASK   = O_BID + PRICE_BITS;
	localparam int unsigned O_DEPTH = O_ASK + PRICE_BITS;

	trk_cmd_t cmd;
	trk_sts_t sts;

	logic [PRICE_BITS-1:0] open_high, open_low, open_range;
	logic [PRICE_BITS-1:0] day_high, day_low, day_range;
	logic [POS_BITS-1:0]   close_position;

	// registers are plain flops, every write transaction lands at once
	assign cfg_ready = 1'b1;

	// sequencing of one transaction: accept, fold in, gate, divide, hand off
	trk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trk_datapath #(
		.PRICE_BITS (PRICE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.trading_day    (s_tdata[DAY_BITS-1:0]),
		.bar_time       (s_tdata[O_TIME +: TIME_BITS]),
		.bar_high       (s_tdata[O_HIGH +: PRICE_BITS]),
		.bar_low        (s_tdata[O_LOW +: PRICE_BITS]),
		.bar_close      (s_tdata[O_CLOSE +: PRICE_BITS]),
		.best_bid       (s_tdata[O_BID +: PRICE_BITS]),
		.best_ask       (s_tdata[O_ASK +: PRICE_BITS]),
		.depth_levels   (s_tdata[O_DEPTH +: DEPTH_BITS]),
		.book_stale     (s_tuser),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.open_high      (open_high),
		.open_low       (open_low),
		.open_range     (open_range),
		.day_high       (day_high),
		.day_low        (day_low),
		.day_range      (day_range),
		.close_position (close_position)
	);

	// result fields packed from the lowest bit up, zero filled to whole bytes
	assign m_tdata = OUT_TDATA'({close_position, day_range, day_low, day_high,
	                             open_range, open_low, open_high});

endmodule
